/* src/mli_pkg.sv */
package mli_pkg;

  // Action codes of one input word
  localparam logic [1:0] ACT_EXEC     = 2'd0;
  localparam logic [1:0] ACT_WR_STORE = 2'd1;
  localparam logic [1:0] ACT_WR_ACC   = 2'd2;
  localparam logic [1:0] ACT_RD_STORE = 2'd3;

  // High opcode nibble: operation
  localparam logic [3:0] OP_ORL = 4'h4;
  localparam logic [3:0] OP_ANL = 4'h5;
  localparam logic [3:0] OP_XRL = 4'h6;

  // Low opcode nibble: addressing mode
  localparam logic [3:0] MODE_DIR_A   = 4'h2;
  localparam logic [3:0] MODE_DIR_IMM = 4'h3;
  localparam logic [3:0] MODE_A_IMM   = 4'h4;
  localparam logic [3:0] MODE_A_DIR   = 4'h5;

  localparam int unsigned STORE_DEPTH = 256;
  localparam int unsigned DATA_W      = 8;

  // Controller to datapath commands
  typedef struct packed {
    logic cap;     // latch input word, read first operand
    logic rd_ptr;  // read at the pointer just fetched
    logic exe;     // compute, write back, present result
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic indirect;  // input word needs a pointer read
  } dp_sts_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PTR  = 3'b010,
    ST_EXE  = 3'b100
  } state_t;

  // Pick AND, OR or XOR from the high nibble
  function automatic logic [7:0] logic_op(input logic [3:0] sel,
                                          input logic [7:0] x,
                                          input logic [7:0] y);
    logic [7:0] res;
    if (sel == OP_ANL) res = x & y;
    else if (sel == OP_ORL) res = x | y;
    else res = x ^ y;
    return res;
  endfunction

  // True for an ANL, ORL or XRL form
  function automatic logic op_ok(input logic [7:0] opc);
    logic hi_ok;
    hi_ok = (opc[7:4] == OP_ORL) || (opc[7:4] == OP_ANL) || (opc[7:4] == OP_XRL);
    return hi_ok && (opc[3:1] != 3'b000);
  endfunction

endpackage

/* src/mli_ram.sv */
module mli_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/mli_ctrl.sv */
module mli_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  mli_pkg::dp_sts_t sts,
  output mli_pkg::dp_cmd_t cmd,
  output logic             busy
);
  import mli_pkg::*;

  state_t state_r, state_nxt;

  // Sequence: accept, optional pointer read, execute
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.cap   = 1'b1;
          state_nxt = sts.indirect ? ST_PTR : ST_EXE;
        end
      end
      ST_PTR: begin
        cmd.rd_ptr = 1'b1;
        state_nxt  = ST_EXE;
      end
      ST_EXE: begin
        cmd.exe   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

/* src/mli_dp.sv */
module mli_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  mli_pkg::dp_cmd_t cmd,
  output mli_pkg::dp_sts_t sts,
  input  logic [1:0]       in_action,
  input  logic [7:0]       in_opcode,
  input  logic [7:0]       in_byte_one,
  input  logic [7:0]       in_byte_two,
  input  logic             bank_we,
  input  logic [1:0]       bank_wdata,
  output logic [1:0]       bank,
  output logic             out_valid,
  output logic [7:0]       out_result_value,
  output logic [7:0]       out_dest_address,
  output logic             out_dest_is_acc,
  output logic [1:0]       out_instr_length,
  output logic             out_bad_opcode
);
  import mli_pkg::*;

  logic [1:0] bank_r;
  logic [7:0] acc_r;
  logic [1:0] act_r;
  logic [7:0] op_r;
  logic [7:0] b1_r;
  logic [7:0] b2_r;

  logic [STORE_DEPTH-1:0] vld_r;
  logic                   rd_vld_r;
  logic [7:0]             ram_rdata;
  logic [7:0]             rd_eff;
  logic [7:0]             in_raddr;
  logic [7:0]             raddr;
  logic                   re;

  logic [7:0] val;
  logic [7:0] dest;
  logic       to_acc;
  logic [1:0] len;
  logic       bad;
  logic       st_we;
  logic       acc_we;
  logic [3:0] hi;
  logic [3:0] lo;

  logic       out_valid_r;
  logic [7:0] out_val_r;
  logic [7:0] out_dest_r;
  logic       out_acc_r;
  logic [1:0] out_len_r;
  logic       out_bad_r;

  // Never-written entries read as zero
  assign rd_eff = rd_vld_r ? ram_rdata : 8'h00;

  // First read address straight from the input word
  always_comb begin
    in_raddr     = in_byte_one;
    sts.indirect = 1'b0;
    if (in_action == ACT_EXEC) begin
      if (in_opcode[3]) begin
        in_raddr = {3'b000, bank_r, in_opcode[2:0]};
      end else if (in_opcode[3:1] == 3'b011) begin
        in_raddr     = {3'b000, bank_r, 2'b00, in_opcode[0]};
        sts.indirect = op_ok(in_opcode);
      end
    end
  end

  assign re    = cmd.cap | cmd.rd_ptr;
  assign raddr = cmd.rd_ptr ? rd_eff : in_raddr;

  mli_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(b1_r),
    .wdata(val),
    .re   (re),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  // Track written entries alongside the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (st_we) begin
      vld_r[b1_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_vld_r <= vld_r[raddr];
    end
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      act_r <= in_action;
      op_r  <= in_opcode;
      b1_r  <= in_byte_one;
      b2_r  <= in_byte_two;
    end
  end

  assign hi = op_r[7:4];
  assign lo = op_r[3:0];

  // Execute the held word
  always_comb begin
    val    = 8'h00;
    dest   = 8'h00;
    to_acc = 1'b0;
    len    = 2'd0;
    bad    = 1'b0;
    st_we  = 1'b0;
    acc_we = 1'b0;
    case (act_r)
      ACT_WR_STORE: begin
        st_we = cmd.exe;
        val   = b2_r;
        dest  = b1_r;
      end
      ACT_WR_ACC: begin
        acc_we = cmd.exe;
        val    = b2_r;
        to_acc = 1'b1;
      end
      ACT_RD_STORE: begin
        val = rd_eff;
      end
      ACT_EXEC: begin
        if (!op_ok(op_r)) begin
          bad = 1'b1;
        end else if (lo == MODE_DIR_A || lo == MODE_DIR_IMM) begin
          val   = logic_op(hi, rd_eff, (lo == MODE_DIR_A) ? acc_r : b2_r);
          st_we = cmd.exe;
          dest  = b1_r;
          len   = (lo == MODE_DIR_A) ? 2'd2 : 2'd3;
        end else begin
          val    = logic_op(hi, (lo == MODE_A_IMM) ? b1_r : rd_eff, acc_r);
          acc_we = cmd.exe;
          to_acc = 1'b1;
          len    = (lo == MODE_A_IMM || lo == MODE_A_DIR) ? 2'd2 : 2'd1;
        end
      end
      default: begin
        bad = 1'b0;
      end
    endcase
  end

  // Accumulator and bank register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= 8'h00;
      bank_r <= 2'd0;
    end else begin
      if (acc_we) begin
        acc_r <= val;
      end
      if (bank_we) begin
        bank_r <= bank_wdata;
      end
    end
  end

  // Present the result word for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exe;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exe) begin
      out_val_r  <= val;
      out_dest_r <= dest;
      out_acc_r  <= to_acc;
      out_len_r  <= len;
      out_bad_r  <= bad;
    end
  end

  assign bank             = bank_r;
  assign out_valid        = out_valid_r;
  assign out_result_value = out_val_r;
  assign out_dest_address = out_dest_r;
  assign out_dest_is_acc  = out_acc_r;
  assign out_instr_length = out_len_r;
  assign out_bad_opcode   = out_bad_r;

endmodule

/* src/mcs51_logic_instruction_unit.sv */
// Channel   Handshake                          Payload
// input     start, busy (taken: start & !busy) in_action, in_opcode, in_byte_one, in_byte_two
// result    out_valid, one-cycle strobe        out_result_value, out_dest_address,
//                                              out_dest_is_acc, out_instr_length, out_bad_opcode
// config    psel, penable, pwrite, pready      paddr, pwdata, prdata (register_bank at 0)
//
// A word passes through accept and execute; an A,@Ri word also has a pointer state,
// since the pointer and then the operand each go through the store's registered read port.
// The result strobe follows in the cycle after the execute cycle; a new word may be
// taken in that same cycle. rst_n is synchronous; the store needs no clearing
// pass, per-entry written bits make it read as zero right after reset.
// The receiver cannot stall; results are never held.
module mcs51_logic_instruction_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_byte_one,
  input  logic [7:0]  in_byte_two,
  output logic        out_valid,
  output logic [7:0]  out_result_value,
  output logic [7:0]  out_dest_address,
  output logic        out_dest_is_acc,
  output logic [1:0]  out_instr_length,
  output logic        out_bad_opcode,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mli_pkg::*;

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [1:0] bank;
  logic       bank_we;
  logic       reg_sel;

  // Register port: one register, decoded at byte addresses zero to three (paddr[2] low)
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign bank_we = psel & penable & pwrite & reg_sel;
  assign prdata  = reg_sel ? {30'd0, bank} : 32'd0;

  mli_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  mli_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_action),
    .in_opcode       (in_opcode),
    .in_byte_one     (in_byte_one),
    .in_byte_two     (in_byte_two),
    .bank_we         (bank_we),
    .bank_wdata      (pwdata[1:0]),
    .bank            (bank),
    .out_valid       (out_valid),
    .out_result_value(out_result_value),
    .out_dest_address(out_dest_address),
    .out_dest_is_acc (out_dest_is_acc),
    .out_instr_length(out_instr_length),
    .out_bad_opcode  (out_bad_opcode)
  );

  // A result only follows a busy cycle
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a word in flight");

  // An accepted word makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not start execution");

  // One strobe per word
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe repeated");

  // A bad opcode writes nothing
  a_bad_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_opcode) |->
      (out_instr_length == 2'd0 && !out_dest_is_acc && out_dest_address == 8'h00))
    else $error("bad opcode reported a destination");

endmodule
